// File: rtl/tmb_pkg.sv
package tmb_pkg;

	// default sizes of the map and the screen
	localparam int DEF_MAX_MAP_WIDTH  = 1024;
	localparam int DEF_MAX_MAP_HEIGHT = 1024;
	localparam int DEF_SCREEN_W       = 320;
	localparam int DEF_SCREEN_H       = 240;

	// tile word layout
	localparam int          ID_W       = 28;
	localparam logic [27:0] ID_MASK    = 28'hFFFFFFF;
	localparam int          FLIP_H_POS = 31;
	localparam int          FLIP_V_POS = 30;
	localparam int          FLIP_D_POS = 29;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_TILE_SIZE     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE         = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ATLAS_COLUMNS = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X      = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y      = 3'd6;

	// command queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// raw configuration registers
	typedef struct packed {
		logic [8:0]  tile_size;
		logic [4:0]  scale;
		logic [8:0]  atlas_columns;
		logic [10:0] map_width;
		logic [10:0] map_height;
		logic [15:0] origin_x;
		logic [15:0] origin_y;
	} cfg_t;

	// classified tile, handed from front to back
	typedef struct packed {
		logic        visible;
		logic [27:0] idx;
		logic [23:0] dest_x;
		logic [23:0] dest_y;
		logic [12:0] dest_size;
		logic        flip_h;
		logic        flip_v;
		logic        last_tile;
	} cmd_t;

	// tile size and atlas columns saturate to 1..256
	function automatic logic [8:0] sat_256(input logic [8:0] v);
		logic [8:0] r;
		r = v;
		if (v == 9'd0) r = 9'd1;
		else if (v > 9'd256) r = 9'd256;
		return r;
	endfunction

	// scale saturates to 1..16
	function automatic logic [4:0] sat_scale(input logic [4:0] v);
		logic [4:0] r;
		r = v;
		if (v == 5'd0) r = 5'd1;
		else if (v > 5'd16) r = 5'd16;
		return r;
	endfunction

endpackage

// File: rtl/tmb_front.sv
module tmb_front import tmb_pkg::*; #(
	parameter int MAX_MAP_WIDTH  = DEF_MAX_MAP_WIDTH,
	parameter int MAX_MAP_HEIGHT = DEF_MAX_MAP_HEIGHT,
	parameter int SCREEN_W       = DEF_SCREEN_W,
	parameter int SCREEN_H       = DEF_SCREEN_H
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [31:0] tile_word,
	input  cfg_t        cfg,
	input  logic        q_full,
	output logic        q_wr,
	output cmd_t        q_cmd
);

	localparam int CW  = (MAX_MAP_WIDTH > 1) ? $clog2(MAX_MAP_WIDTH) : 1;
	localparam int RW  = (MAX_MAP_HEIGHT > 1) ? $clog2(MAX_MAP_HEIGHT) : 1;
	localparam int PXW = CW + 13;
	localparam int PYW = RW + 13;
	localparam int DXW = (CW + 15 > 25) ? CW + 15 : 25;
	localparam int DYW = (RW + 15 > 25) ? RW + 15 : 25;
	localparam logic [16:0] MAXW = 17'(MAX_MAP_WIDTH);
	localparam logic [16:0] MAXH = 17'(MAX_MAP_HEIGHT);

	logic [CW-1:0]  col_q;
	logic [RW-1:0]  row_q;
	logic [16:0]    w_sat, h_sat;
	logic           end_row, end_map;
	logic           accept, adv;
	logic [8:0]     ts;
	logic [4:0]     sc;

	logic           v_s1, v_s2, v_s3;
	logic [31:0]    word_s1, word_s2;
	logic [CW-1:0]  col_s1;
	logic [RW-1:0]  row_s1;
	logic [12:0]    edge_s1, edge_s2;
	logic           last_s1, last_s2;
	logic [PXW-1:0] px_s2;
	logic [PYW-1:0] py_s2;
	cmd_t           cmd_s3;

	logic signed [DXW-1:0] dx_full;
	logic signed [DYW-1:0] dy_full;
	logic                  on_screen;
	logic                  vis;
	logic [ID_W-1:0]       id;
	cmd_t                  cmd_d;

	// whole pipeline stalls when the last stage cannot enter the queue
	assign adv    = !(v_s3 && q_full);
	assign full   = !adv;
	assign accept = push && !full;
	assign q_wr   = v_s3 && !q_full;
	assign q_cmd  = cmd_s3;

	// saturated map size and end of row / map for the current cell
	always_comb begin
		w_sat = 17'(cfg.map_width);
		if (cfg.map_width == 11'd0) w_sat = 17'd1;
		else if (w_sat > MAXW) w_sat = MAXW;
		h_sat = 17'(cfg.map_height);
		if (cfg.map_height == 11'd0) h_sat = 17'd1;
		else if (h_sat > MAXH) h_sat = MAXH;
		end_row = 17'(col_q) >= (w_sat - 17'd1);
		end_map = end_row && (17'(row_q) >= (h_sat - 17'd1));
	end

	// column and row counters advance on each request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (end_row) begin
				col_q <= '0;
				row_q <= end_map ? '0 : RW'(row_q + 1'b1);
			end else begin
				col_q <= CW'(col_q + 1'b1);
			end
		end
	end

	assign ts = sat_256(cfg.tile_size);
	assign sc = sat_scale(cfg.scale);

	// valid bits of the three stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// stage 1: capture cell, counters and destination edge
	always_ff @(posedge clk) begin
		if (adv) begin
			word_s1 <= tile_word;
			col_s1  <= col_q;
			row_s1  <= row_q;
			edge_s1 <= 13'(13'(ts) * 13'(sc));
			last_s1 <= end_map;
		end
	end

	// stage 2: counters times edge
	always_ff @(posedge clk) begin
		if (adv) begin
			word_s2 <= word_s1;
			edge_s2 <= edge_s1;
			last_s2 <= last_s1;
			px_s2   <= PXW'(PXW'(col_s1) * PXW'(edge_s1));
			py_s2   <= PYW'(PYW'(row_s1) * PYW'(edge_s1));
		end
	end

	// stage 3: add origin, cull against the screen, decode flips
	always_comb begin
		dx_full   = $signed(DXW'(px_s2)) + DXW'($signed(cfg.origin_x));
		dy_full   = $signed(DYW'(py_s2)) + DYW'($signed(cfg.origin_y));
		on_screen = (dx_full <= $signed(DXW'(SCREEN_W)))
			&& (dy_full <= $signed(DYW'(SCREEN_H)))
			&& ((dx_full + $signed(DXW'(edge_s2))) > $signed(DXW'(0)))
			&& ((dy_full + $signed(DYW'(edge_s2))) > $signed(DYW'(0)));
		id        = word_s2[ID_W-1:0] & ID_MASK;
		vis       = (id != '0) && on_screen;

		cmd_d           = '0;
		cmd_d.visible   = vis;
		cmd_d.idx       = id - 1'b1;
		cmd_d.dest_x    = dx_full[23:0];
		cmd_d.dest_y    = dy_full[23:0];
		cmd_d.dest_size = edge_s2;
		cmd_d.last_tile = last_s2;
		// priority: horizontal, vertical, then diagonal as both
		if (vis) begin
			if (word_s2[FLIP_H_POS]) begin
				cmd_d.flip_h = 1'b1;
			end else if (word_s2[FLIP_V_POS]) begin
				cmd_d.flip_v = 1'b1;
			end else if (word_s2[FLIP_D_POS]) begin
				cmd_d.flip_h = 1'b1;
				cmd_d.flip_v = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s3 <= cmd_d;
		end
	end

	// counters never leave the largest map
	a_counter_range: assert property (@(posedge clk) disable iff (!arst_n)
		(17'(col_q) < MAXW) && (17'(row_q) < MAXH))
		else $error("tile counter beyond map limit");

endmodule

// File: rtl/tmb_cmd_fifo.sv
module tmb_cmd_fifo import tmb_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  cmd_t wr_cmd,
	output logic q_full,
	input  logic rd_en,
	output cmd_t rd_cmd,
	output logic q_empty
);

	localparam int QPW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCW = $clog2(QUEUE_DEPTH + 1);

	cmd_t           mem_q [QUEUE_DEPTH];
	logic [QPW-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCW-1:0] count_q;

	assign q_full  = count_q == QCW'(QUEUE_DEPTH);
	assign q_empty = count_q == '0;
	assign rd_cmd  = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == QPW'(QUEUE_DEPTH - 1)) ? '0 : QPW'(wr_ptr_q + 1'b1);
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == QPW'(QUEUE_DEPTH - 1)) ? '0 : QPW'(rd_ptr_q + 1'b1);
			end
			if (wr_en && !rd_en) count_q <= QCW'(count_q + 1'b1);
			else if (rd_en && !wr_en) count_q <= QCW'(count_q - 1'b1);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> !q_full)
		else $error("command queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> !q_empty)
		else $error("command queue read while empty");

endmodule

// File: rtl/tmb_back.sv
module tmb_back import tmb_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  logic               q_empty,
	input  cmd_t               q_cmd,
	output logic               q_rd,
	output logic               empty,
	input  logic               pop,
	output logic               visible,
	output logic [15:0]        src_x,
	output logic [35:0]        src_y,
	output logic signed [23:0] dest_x,
	output logic signed [23:0] dest_y,
	output logic [12:0]        dest_size,
	output logic               flip_h,
	output logic               flip_v,
	output logic               last_tile
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DIV  = 3'b010,
		ST_MUL  = 3'b100
	} back_state_t;

	back_state_t state_q;
	cmd_t        cmd_q;
	logic [8:0]  rem_q;
	logic [27:0] quot_q;
	logic [4:0]  cnt_q;
	logic        out_valid_q;

	logic [8:0]  ts, cols;
	logic [8:0]  shifted;
	logic [9:0]  diff;
	logic        ge;
	logic        out_load;

	assign ts       = sat_256(cfg.tile_size);
	assign cols     = sat_256(cfg.atlas_columns);
	assign q_rd     = (state_q == ST_IDLE) && !q_empty;
	assign out_load = (state_q == ST_MUL) && (!out_valid_q || pop);
	assign empty    = !out_valid_q;

	// one restoring divide step per cycle
	assign shifted = {rem_q[7:0], quot_q[27]};
	assign diff    = {1'b0, shifted} - {1'b0, cols};
	assign ge      = !diff[9];

	// sequencer: fetch, divide if visible, scale, hand to the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						state_q <= q_cmd.visible ? ST_DIV : ST_MUL;
						cnt_q   <= 5'(ID_W - 1);
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) state_q <= ST_MUL;
				end
				ST_MUL: begin
					if (out_load) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// command and divider datapath
	always_ff @(posedge clk) begin
		if (q_rd) begin
			cmd_q  <= q_cmd;
			rem_q  <= '0;
			quot_q <= q_cmd.idx;
		end else if (state_q == ST_DIV) begin
			rem_q  <= ge ? diff[8:0] : shifted;
			quot_q <= {quot_q[26:0], ge};
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			visible   <= cmd_q.visible;
			src_x     <= cmd_q.visible ? 16'(16'(rem_q[7:0]) * 16'(ts)) : '0;
			src_y     <= cmd_q.visible ? 36'(37'(quot_q) * 37'(ts)) : '0;
			dest_x    <= cmd_q.dest_x;
			dest_y    <= cmd_q.dest_y;
			dest_size <= cmd_q.dest_size;
			flip_h    <= cmd_q.flip_h;
			flip_v    <= cmd_q.flip_v;
			last_tile <= cmd_q.last_tile;
		end
	end

	// partial remainder stays below the divisor
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (rem_q < cols))
		else $error("divider remainder out of range");

	// hidden tiles carry no source position or flips
	a_hidden_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !visible) |->
		(src_x == '0) && (src_y == '0) && !flip_h && !flip_v)
		else $error("hidden tile with source data");

endmodule

// File: rtl/tile_map_blit_command_generator.sv
// Tile map blit command generator.
// Input channel: push / full with tile_word; a request is taken when push is
// high and full is low. Cells arrive in row-major order; the block keeps its
// own column and row counters, which wrap after the last cell of the map.
// Result channel: empty / pop; the oldest command sits on the result ports
// while empty is low and is taken when pop is high and empty is low.
// Configuration: wr_en / wr_index / wr_data, one register per cycle. The user
// must write while no request is in flight; the block does not enforce it.
// Counters are not touched by writes. A visible tile passes through the 28-step
// atlas index divider in the back end, while a hidden one skips the divider;
// the back end takes one command at a time from the command queue.
// A 3-stage front end and a 2-entry command queue keep taking requests while
// the divider works or a result waits; full rises once they are all taken.
// When pop stays low the finished command is held and the back end waits.
// Reset: counters zero, queue and result register empty, registers at their
// reset values (tile size 16, scale 1, one atlas column, 1 x 1 map, origin 0).
module tile_map_blit_command_generator import tmb_pkg::*; #(
	parameter int MAX_MAP_WIDTH  = DEF_MAX_MAP_WIDTH,
	parameter int MAX_MAP_HEIGHT = DEF_MAX_MAP_HEIGHT,
	parameter int SCREEN_W       = DEF_SCREEN_W,
	parameter int SCREEN_H       = DEF_SCREEN_H
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	input  logic                  push,
	output logic                  full,
	input  logic [31:0]           tile_word,
	output logic                  empty,
	input  logic                  pop,
	output logic                  visible,
	output logic [15:0]           src_x,
	output logic [35:0]           src_y,
	output logic signed [23:0]    dest_x,
	output logic signed [23:0]    dest_y,
	output logic [12:0]           dest_size,
	output logic                  flip_h,
	output logic                  flip_v,
	output logic                  last_tile
);

	cfg_t cfg_q;
	logic q_full, q_empty, q_wr, q_rd;
	cmd_t q_wr_cmd, q_rd_cmd;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tile_size     <= 9'd16;
			cfg_q.scale         <= 5'd1;
			cfg_q.atlas_columns <= 9'd1;
			cfg_q.map_width     <= 11'd1;
			cfg_q.map_height    <= 11'd1;
			cfg_q.origin_x      <= '0;
			cfg_q.origin_y      <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_TILE_SIZE:     cfg_q.tile_size     <= wr_data[8:0];
				REG_SCALE:         cfg_q.scale         <= wr_data[4:0];
				REG_ATLAS_COLUMNS: cfg_q.atlas_columns <= wr_data[8:0];
				REG_MAP_WIDTH:     cfg_q.map_width     <= wr_data[10:0];
				REG_MAP_HEIGHT:    cfg_q.map_height    <= wr_data[10:0];
				REG_ORIGIN_X:      cfg_q.origin_x      <= wr_data[15:0];
				REG_ORIGIN_Y:      cfg_q.origin_y      <= wr_data[15:0];
				default: ;
			endcase
		end
	end

	// front end: counters, placement, culling, flip decode
	tmb_front #(
		.MAX_MAP_WIDTH  (MAX_MAP_WIDTH),
		.MAX_MAP_HEIGHT (MAX_MAP_HEIGHT),
		.SCREEN_W       (SCREEN_W),
		.SCREEN_H       (SCREEN_H)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.tile_word (tile_word),
		.cfg       (cfg_q),
		.q_full    (q_full),
		.q_wr      (q_wr),
		.q_cmd     (q_wr_cmd)
	);

	// command queue
	tmb_cmd_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_wr),
		.wr_cmd  (q_wr_cmd),
		.q_full  (q_full),
		.rd_en   (q_rd),
		.rd_cmd  (q_rd_cmd),
		.q_empty (q_empty)
	);

	// back end: atlas position and result register
	tmb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_empty   (q_empty),
		.q_cmd     (q_rd_cmd),
		.q_rd      (q_rd),
		.empty     (empty),
		.pop       (pop),
		.visible   (visible),
		.src_x     (src_x),
		.src_y     (src_y),
		.dest_x    (dest_x),
		.dest_y    (dest_y),
		.dest_size (dest_size),
		.flip_h    (flip_h),
		.flip_v    (flip_v),
		.last_tile (last_tile)
	);

endmodule
